FILE: src/mse_pkg.sv
// Package for the MIPS subset execute unit: payload structs, opcodes, states.
// No dependencies.
`timescale 1ns / 1ps
package mse_pkg;

    localparam int RegCountDefault = 32;

    typedef struct packed {
        logic        req_type;
        logic [31:0] instruction;
        logic [31:0] current_pc;
        logic [31:0] load_data;
    } mse_in_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halt;
        logic [2:0]  mem_op;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic [2:0]  flags_out;
        logic        syscall_request;
        logic [31:0] syscall_code;
        logic [31:0] syscall_arg;
        logic [4:0]  write_index;
        logic [31:0] write_value;
    } mse_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MDIV,
        ST_DONE
    } mse_state_t;

    // multiply/divide unit commands
    typedef enum logic [1:0] {
        MD_MULS,
        MD_MULU,
        MD_DIVS,
        MD_DIVU
    } md_op_t;

    typedef struct packed {
        logic        start;
        md_op_t      op;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [2:0]  flags;
    } md_rsp_t;

    localparam logic [5:0] OP_SPECIAL  = 6'h00;
    localparam logic [5:0] OP_J        = 6'h02;
    localparam logic [5:0] OP_JAL      = 6'h03;
    localparam logic [5:0] OP_BEQ      = 6'h04;
    localparam logic [5:0] OP_BNE      = 6'h05;
    localparam logic [5:0] OP_ADDI     = 6'h08;
    localparam logic [5:0] OP_ADDI_UNS = 6'h09;
    localparam logic [5:0] OP_SLTI     = 6'h0A;
    localparam logic [5:0] OP_SLTI_UNS = 6'h0B;
    localparam logic [5:0] OP_ANDI     = 6'h0C;
    localparam logic [5:0] OP_ORI      = 6'h0D;
    localparam logic [5:0] OP_XORI     = 6'h0E;
    localparam logic [5:0] OP_LUI      = 6'h0F;
    localparam logic [5:0] OP_COP0     = 6'h10;
    localparam logic [5:0] OP_LB       = 6'h20;
    localparam logic [5:0] OP_LH       = 6'h21;
    localparam logic [5:0] OP_LW       = 6'h23;
    localparam logic [5:0] OP_LBU      = 6'h24;
    localparam logic [5:0] OP_LHU      = 6'h25;
    localparam logic [5:0] OP_SB       = 6'h28;
    localparam logic [5:0] OP_SH       = 6'h29;
    localparam logic [5:0] OP_SW       = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_ERET    = 6'h18;
    localparam logic [4:0] RS_ERET    = 5'h10;

    localparam logic [2:0] MEM_NONE = 3'd0;
    localparam logic [2:0] MEM_RDB  = 3'd1;
    localparam logic [2:0] MEM_RDH  = 3'd2;
    localparam logic [2:0] MEM_RDW  = 3'd3;
    localparam logic [2:0] MEM_WRB  = 3'd4;
    localparam logic [2:0] MEM_WRH  = 3'd5;
    localparam logic [2:0] MEM_WRW  = 3'd6;

    localparam logic [2:0] LD_NONE = 3'd0;
    localparam logic [2:0] LD_B    = 3'd1;
    localparam logic [2:0] LD_H    = 3'd2;
    localparam logic [2:0] LD_W    = 3'd3;
    localparam logic [2:0] LD_BU   = 3'd4;
    localparam logic [2:0] LD_HU   = 3'd5;

    localparam logic [4:0]  REG_V0   = 5'd2;
    localparam logic [4:0]  REG_A0   = 5'd4;
    localparam logic [4:0]  REG_RA   = 5'd31;
    localparam logic [31:0] SYS_EXIT = 32'd10;

endpackage

FILE: src/mips_subset_execute_unit_top.sv
// MIPS subset execute unit top: register file memory, sequencer, ALU, result register.
// Depends on mse_pkg and mse_muldiv.
//
//  channel | signals                       | direction
//  in      | in_valid, in_ready, in_data   | item in (mse_in_t)
//  out     | out_valid, out_ready, out_data| result out (mse_out_t)
//
// out_valid rises after the states READ (register file read), EXEC (execute) and DONE (result);
// the next item is accepted only once the sequencer is back in IDLE.
// MULT/MULTU/DIV/DIVU (not by zero) wait in MDIV on the shift-add / restoring divide unit.
// Reset clears the register file, no item accepted then.
// A result waiting on out_ready holds the next item off until taken.
`timescale 1ns / 1ps
module mips_subset_execute_unit_top #(
    parameter int RegCount = mse_pkg::RegCountDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mse_pkg::mse_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mse_pkg::mse_out_t out_data
);
    import mse_pkg::*;

    localparam int IdxW = (RegCount > 1) ? $clog2(RegCount) : 1;

    logic [31:0] rf_mem [RegCount];
    logic [31:0] rd_a_reg, rd_b_reg;
    logic [IdxW-1:0] ra_idx, rb_idx;
    logic        ra_ok_reg, rb_ok_reg;
    logic        rf_we;
    logic [IdxW-1:0] rf_widx;
    logic [31:0] rf_wval;

    mse_state_t  state_reg, state_next;
    logic        clr_reg, clr_next;
    logic [IdxW:0] clr_cnt_reg, clr_cnt_next;

    mse_in_t     item_reg;
    mse_out_t    res_reg, res_next;
    logic        res_valid_reg, res_valid_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [2:0]  flags_reg, flags_next;
    logic [2:0]  pk_reg, pk_next;
    logic [4:0]  pd_reg, pd_next;

    md_req_t     md_req;
    md_rsp_t     md_rsp;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b, ea, br_tgt, pc4;
    logic [32:0] add_r;
    logic [31:0] sub_r;
    logic        sub_bor;
    logic        accept;

    // exec decode
    logic        ex_we;
    logic [4:0]  ex_widx;
    logic [31:0] ex_wval;
    logic        ex_md;
    mse_out_t    ex_out;
    logic [31:0] ex_hi, ex_lo;
    logic [2:0]  ex_flags, ex_pk;
    logic [4:0]  ex_pd;
    logic [31:0] ld_v;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !clr_reg && !res_valid_reg;

    assign op   = item_reg.instruction[31:26];
    assign rs   = item_reg.instruction[25:21];
    assign rt   = item_reg.instruction[20:16];
    assign rd   = item_reg.instruction[15:11];
    assign sh   = item_reg.instruction[10:6];
    assign fn   = item_reg.instruction[5:0];
    assign imm  = {16'd0, item_reg.instruction[15:0]};
    assign simm = {{16{item_reg.instruction[15]}}, item_reg.instruction[15:0]};
    assign a    = ra_ok_reg ? rd_a_reg : 32'd0;
    assign b    = rb_ok_reg ? rd_b_reg : 32'd0;

    // syscall reads v0/a0 through the same two ports
    assign ra_idx = (op == OP_SPECIAL && fn == FN_SYSCALL) ? REG_V0[IdxW-1:0] : rs[IdxW-1:0];
    assign rb_idx = (op == OP_SPECIAL && fn == FN_SYSCALL) ? REG_A0[IdxW-1:0] : rt[IdxW-1:0];

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_widx] <= rf_wval;
        rd_a_reg <= rf_mem[ra_idx];
        rd_b_reg <= rf_mem[rb_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_ok_reg <= 1'b0;
            rb_ok_reg <= 1'b0;
        end
        else
        begin
            ra_ok_reg <= (ra_idx != '0) && ({27'd0, (op == OP_SPECIAL && fn == FN_SYSCALL)
                         ? REG_V0 : rs} < 32'(RegCount));
            rb_ok_reg <= (rb_idx != '0) && ({27'd0, (op == OP_SPECIAL && fn == FN_SYSCALL)
                         ? REG_A0 : rt} < 32'(RegCount));
        end
    end

    assign ea      = a + simm;
    assign pc4     = item_reg.current_pc + 32'd4;
    assign br_tgt  = item_reg.current_pc + {simm[29:0], 2'b00};
    assign sub_r   = a - b;
    assign sub_bor = a < b;

    always_comb
    begin
        ex_we    = 1'b0;
        ex_widx  = 5'd0;
        ex_wval  = 32'd0;
        ex_md    = 1'b0;
        ex_hi    = hi_reg;
        ex_lo    = lo_reg;
        ex_flags = flags_reg;
        ex_pk    = pk_reg;
        ex_pd    = pd_reg;
        ex_out   = '0;
        ex_out.next_pc = item_reg.current_pc;
        add_r    = {1'b0, a} + {1'b0, (op == OP_SPECIAL) ? b : simm};
        ld_v     = 32'd0;
        md_req   = '0;
        if (item_reg.req_type)
        begin
            case (pk_reg)
                LD_B:    ld_v = {{24{item_reg.load_data[7]}}, item_reg.load_data[7:0]};
                LD_H:    ld_v = {{16{item_reg.load_data[15]}}, item_reg.load_data[15:0]};
                LD_W:    ld_v = item_reg.load_data;
                LD_BU:   ld_v = {24'd0, item_reg.load_data[7:0]};
                LD_HU:   ld_v = {16'd0, item_reg.load_data[15:0]};
                default: ld_v = 32'd0;
            endcase
            if (pk_reg inside {LD_B, LD_H, LD_W, LD_BU, LD_HU})
            begin
                ex_we   = 1'b1;
                ex_widx = pd_reg;
                ex_wval = ld_v;
                ex_pk   = LD_NONE;
                ex_pd   = 5'd0;
            end
        end
        else
        begin
            case (op)
                OP_SPECIAL:
                begin
                    case (fn)
                        FN_SLL:  begin ex_we = 1'b1; ex_widx = rd; ex_wval = b << sh; end
                        FN_SRL:  begin ex_we = 1'b1; ex_widx = rd; ex_wval = b >> sh; end
                        FN_SRA:  begin ex_we = 1'b1; ex_widx = rd;
                                 ex_wval = $unsigned($signed(b) >>> sh); end
                        FN_SLLV: begin ex_we = 1'b1; ex_widx = rd; ex_wval = b << a[4:0]; end
                        FN_SRLV: begin ex_we = 1'b1; ex_widx = rd; ex_wval = b >> a[4:0]; end
                        FN_SRAV: begin ex_we = 1'b1; ex_widx = rd;
                                 ex_wval = $unsigned($signed(b) >>> a[4:0]); end
                        FN_JR:   ex_out.next_pc = a;
                        FN_JALR: begin ex_out.next_pc = a; ex_we = 1'b1; ex_widx = rd;
                                 ex_wval = item_reg.current_pc; end
                        FN_SYSCALL:
                        begin
                            ex_out.syscall_code = a;
                            ex_out.syscall_arg  = b;
                            if (a == SYS_EXIT)
                                ex_out.halt = 1'b1;
                            else
                                ex_out.syscall_request = 1'b1;
                        end
                        FN_BREAK: ex_out.halt = 1'b1;
                        FN_MFHI: begin ex_we = 1'b1; ex_widx = rd; ex_wval = hi_reg; end
                        FN_MTHI: ex_hi = a;
                        FN_MFLO: begin ex_we = 1'b1; ex_widx = rd; ex_wval = lo_reg; end
                        FN_MTLO: ex_lo = a;
                        FN_MULT, FN_MULTU, FN_DIV, FN_DIVU:
                        begin
                            if (!(fn inside {FN_DIV, FN_DIVU}) || b != 32'd0)
                            begin
                                ex_md        = 1'b1;
                                md_req.start = 1'b1;
                                md_req.a     = a;
                                md_req.b     = b;
                                case (fn)
                                    FN_MULT:  md_req.op = MD_MULS;
                                    FN_MULTU: md_req.op = MD_MULU;
                                    FN_DIV:   md_req.op = MD_DIVS;
                                    default:  md_req.op = MD_DIVU;
                                endcase
                            end
                        end
                        FN_ADD, FN_ADDU:
                        begin
                            ex_we = 1'b1; ex_widx = rd; ex_wval = add_r[31:0];
                            ex_flags = {(a[31] ^ add_r[31]) & (b[31] ^ add_r[31]),
                                        add_r[32], add_r[31:0] == 32'd0};
                        end
                        FN_SUB, FN_SUBU:
                        begin
                            ex_we = 1'b1; ex_widx = rd; ex_wval = sub_r;
                            ex_flags = {(a[31] ^ b[31]) & (a[31] ^ sub_r[31]),
                                        sub_bor, sub_r == 32'd0};
                        end
                        FN_AND: begin ex_we = 1'b1; ex_widx = rd; ex_wval = a & b; end
                        FN_OR:  begin ex_we = 1'b1; ex_widx = rd; ex_wval = a | b; end
                        FN_XOR: begin ex_we = 1'b1; ex_widx = rd; ex_wval = a ^ b; end
                        FN_NOR: begin ex_we = 1'b1; ex_widx = rd; ex_wval = ~(a | b); end
                        default: ;
                    endcase
                end
                OP_J, OP_JAL:
                begin
                    if (op == OP_JAL)
                    begin
                        ex_we = 1'b1; ex_widx = REG_RA; ex_wval = pc4;
                    end
                    ex_out.next_pc = {pc4[31:28], item_reg.instruction[25:0], 2'b00};
                end
                OP_BEQ: if (a == b) ex_out.next_pc = br_tgt;
                OP_BNE: if (a != b) ex_out.next_pc = br_tgt;
                OP_ADDI, OP_ADDI_UNS:
                begin
                    ex_we = 1'b1; ex_widx = rt; ex_wval = add_r[31:0];
                    ex_flags = {(a[31] ^ add_r[31]) & (simm[31] ^ add_r[31]),
                                add_r[32], add_r[31:0] == 32'd0};
                end
                OP_SLTI:  begin ex_we = 1'b1; ex_widx = rt;
                          ex_wval = {31'd0, $signed(a) < $signed(simm)}; end
                OP_SLTI_UNS: begin ex_we = 1'b1; ex_widx = rt; ex_wval = {31'd0, a < simm}; end
                OP_ANDI:  begin ex_we = 1'b1; ex_widx = rt; ex_wval = a & imm; end
                OP_ORI:   begin ex_we = 1'b1; ex_widx = rt; ex_wval = a | imm; end
                OP_XORI:  begin ex_we = 1'b1; ex_widx = rt; ex_wval = a ^ imm; end
                OP_LUI:   begin ex_we = 1'b1; ex_widx = rt; ex_wval = {imm[15:0], 16'd0}; end
                OP_COP0:
                    if (!(rs == RS_ERET && fn == FN_ERET && rt == 5'd0 && rd == 5'd0
                          && sh == 5'd0))
                        ex_out.halt = 1'b1;
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                begin
                    ex_out.mem_address = ea;
                    ex_pd = rt;
                    case (op)
                        OP_LB:   begin ex_out.mem_op = MEM_RDB; ex_pk = LD_B; end
                        OP_LH:   begin ex_out.mem_op = MEM_RDH; ex_pk = LD_H; end
                        OP_LW:   begin ex_out.mem_op = MEM_RDW; ex_pk = LD_W; end
                        OP_LBU:  begin ex_out.mem_op = MEM_RDB; ex_pk = LD_BU; end
                        default: begin ex_out.mem_op = MEM_RDH; ex_pk = LD_HU; end
                    endcase
                end
                OP_SB: begin ex_out.mem_op = MEM_WRB; ex_out.mem_address = ea;
                       ex_out.mem_write_data = {24'd0, b[7:0]}; end
                OP_SH: begin ex_out.mem_op = MEM_WRH; ex_out.mem_address = ea;
                       ex_out.mem_write_data = {16'd0, b[15:0]}; end
                OP_SW: begin ex_out.mem_op = MEM_WRW; ex_out.mem_address = ea;
                       ex_out.mem_write_data = b; end
                default: ex_out.halt = 1'b1;
            endcase
        end
        // writes beyond the file or to register 0 are dropped
        if (ex_we && (ex_widx == 5'd0 || {27'd0, ex_widx} >= 32'(RegCount)))
            ex_we = 1'b0;
        if (ex_we)
        begin
            ex_out.write_index = ex_widx;
            ex_out.write_value = ex_wval;
        end
        ex_out.flags_out = ex_flags;
    end

    mse_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   ((state_reg == ST_EXEC) ? md_req : md_req_t'('0)),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = ex_md ? ST_MDIV : ST_DONE;
            ST_MDIV: if (md_rsp.done) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next       = clr_reg;
        clr_cnt_next   = clr_cnt_reg;
        rf_we          = 1'b0;
        rf_widx        = ex_widx[IdxW-1:0];
        rf_wval        = ex_wval;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        flags_next     = flags_reg;
        pk_next        = pk_reg;
        pd_next        = pd_reg;
        if (res_valid_reg && out_ready)
            res_valid_next = 1'b0;
        if (clr_reg)
        begin
            rf_we   = 1'b1;
            rf_widx = clr_cnt_reg[IdxW-1:0];
            rf_wval = 32'd0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (IdxW+1)'(RegCount - 1))
                clr_next = 1'b0;
        end
        case (state_reg)
            ST_EXEC:
            begin
                rf_we      = ex_we;
                hi_next    = ex_hi;
                lo_next    = ex_lo;
                flags_next = ex_flags;
                pk_next    = ex_pk;
                pd_next    = ex_pd;
                res_next   = ex_out;
            end
            ST_MDIV:
                if (md_rsp.done)
                begin
                    hi_next = md_rsp.hi;
                    lo_next = md_rsp.lo;
                    flags_next = md_rsp.flags;
                    res_next.flags_out = md_rsp.flags;
                end
            ST_DONE: res_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            hi_reg        <= 32'd0;
            lo_reg        <= 32'd0;
            flags_reg     <= 3'd0;
            pk_reg        <= LD_NONE;
            pd_reg        <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            flags_reg     <= flags_next;
            pk_reg        <= pk_next;
            pd_reg        <= pd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ)
        else $error("accept did not start sequencer");
    a_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |=> out_valid)
        else $error("result not presented");
    a_no_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.write_index != 5'd0 || out_data.write_value == 32'd0))
        else $error("write value without index");
    a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ready)
        else $error("accept during clear");

endmodule

FILE: src/mse_muldiv.sv
// Iterative multiply/divide unit: one radix-2 step per cycle, 32 steps.
// Depends on mse_pkg.
`timescale 1ns / 1ps
module mse_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  mse_pkg::md_req_t req,
    output mse_pkg::md_rsp_t rsp
);
    import mse_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    md_op_t      op_reg, op_next;
    logic [31:0] acc_reg, acc_next;      // mul: high part; div: remainder
    logic [31:0] q_reg, q_next;          // mul: multiplier/low; div: quotient
    logic [31:0] m_reg, m_next;          // multiplicand/divisor magnitude
    logic        nq_reg, nq_next;
    logic        nr_reg, nr_next;
    logic        ovf_reg, ovf_next;
    logic        done_reg, done_next;
    logic [32:0] sum;
    logic [32:0] trial;
    logic [31:0] fin_hi, fin_lo;
    logic [63:0] neg64;
    logic        is_div;
    logic [2:0]  flg;

    assign is_div = (op_reg == MD_DIVS) || (op_reg == MD_DIVU);
    assign sum    = {1'b0, acc_reg} + {1'b0, m_reg};
    assign trial  = {acc_reg, q_reg[31]} - {1'b0, m_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        m_next    = m_reg;
        nq_next   = nq_reg;
        nr_next   = nr_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            op_next   = req.op;
            acc_next  = 32'd0;
            if (req.op == MD_MULS || req.op == MD_DIVS)
            begin
                q_next  = req.a[31] ? (32'd0 - req.a) : req.a;
                m_next  = req.b[31] ? (32'd0 - req.b) : req.b;
                nq_next = req.a[31] ^ req.b[31];
                nr_next = req.a[31];
            end
            else
            begin
                q_next  = req.a;
                m_next  = req.b;
                nq_next = 1'b0;
                nr_next = 1'b0;
            end
            ovf_next = (req.op == MD_DIVS) && (req.a == 32'h8000_0000)
                       && (req.b == 32'hFFFF_FFFF);
        end
        else if (busy_reg)
        begin
            if (is_div)
            begin
                if (!trial[32])
                begin
                    acc_next = trial[31:0];
                    q_next   = {q_reg[30:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[30:0], q_reg[31]};
                    q_next   = {q_reg[30:0], 1'b0};
                end
            end
            else if (q_reg[0])
            begin
                acc_next = sum[32:1];
                q_next   = {sum[0], q_reg[31:1]};
            end
            else
            begin
                acc_next = {1'b0, acc_reg[31:1]};
                q_next   = {acc_reg[0], q_reg[31:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        m_reg   <= m_next;
        nq_reg  <= nq_next;
        nr_reg  <= nr_next;
        ovf_reg <= ovf_next;
    end

    assign neg64 = 64'd0 - {acc_reg, q_reg};

    always_comb
    begin
        fin_hi = acc_reg;
        fin_lo = q_reg;
        flg    = 3'd0;
        if (is_div)
        begin
            fin_lo = nq_reg ? (32'd0 - q_reg) : q_reg;
            fin_hi = nr_reg ? (32'd0 - acc_reg) : acc_reg;
            flg    = {ovf_reg, 1'b0, (fin_lo == 32'd0)};
        end
        else
        begin
            if (nq_reg)
            begin
                fin_hi = neg64[63:32];
                fin_lo = neg64[31:0];
            end
            flg = {(op_reg == MD_MULS) && (fin_hi != {32{fin_lo[31]}}),
                   (fin_hi != 32'd0), (fin_lo == 32'd0)};
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.hi    = fin_hi;
    assign rsp.lo    = fin_lo;
    assign rsp.flags = flg;

endmodule
